// File: src/pcxrle_pkg.sv
// Shared constants, register codes and channel packing for the PCX RLE pixel decoder.
package pcxrle_pkg;

   // Line store sizing default (bytes per line per plane)
   localparam int MAX_LINE_BYTES = 4096;

   // Run marker decoding
   localparam logic [7:0] RUN_MARK = 8'hC0;
   localparam logic [7:0] RUN_MASK = 8'h3F;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_PLANES_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTES_PER_LINE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_SHIFTS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_SHIFTS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_SHIFTS    = 3'd5;

   // Register reset values
   localparam logic        RST_PLANES_MODE    = 1'b0;
   localparam logic [12:0] RST_IMAGE_WIDTH    = 13'd640;
   localparam logic [12:0] RST_BYTES_PER_LINE = 13'd640;
   localparam logic [7:0]  RST_RED_SHIFTS     = 8'd179;
   localparam logic [7:0]  RST_GREEN_SHIFTS   = 8'd82;
   localparam logic [7:0]  RST_BLUE_SHIFTS    = 8'd3;

   // One color channel: right shift by the low nibble, left shift by the high nibble
   function automatic logic [15:0] channel(input logic [7:0] value, input logic [7:0] shifts);
      logic [22:0] wide;
      wide = {15'd0, value >> shifts[3:0]} << shifts[7:4];
      return wide[15:0];
   endfunction

endpackage

// File: src/pcx_rle_pixel_decoder.sv
// PCX run-length pixel decoder: run sequencer, line store and output register.
//
// Usage:
//  - req_*: one compressed byte per transfer (req_data_byte), req_new_image
//    restarts the line position and drops a pending run marker first.
//  - rsp_*: one pixel per transfer; rsp_last flags the final pixel caused by
//    an input byte, rsp_row_end the last visible pixel of a row.
//  - csr_*: register writes (index, data), always ready; write only while idle.
// Throughput: a literal byte is taken every cycle while the output is not
//   stalled; a run marker places no byte; a run of n bytes places one byte
//   per cycle and the input waits until it ends. Placement is limited by the
//   single run sequencer. A placed byte goes to the s1 stage register, in the
//   same cycle as the registered red/green line store read, then to rsp_*.
// In three-plane mode red and green bytes go into the line store and each
//   visible blue byte reads both planes back to form a 16-bit pixel.
// Reset clears position, pending run and the pipeline and loads register
//   defaults; the line store is not cleared and needs no clearing pass.
// When rsp_ready is low the output register holds, the stage behind it
//   fills, and then the sequencer and req_ready stop until space frees up.
module pcx_rle_pixel_decoder #(
   parameter int MAX_LINE_BYTES = pcxrle_pkg::MAX_LINE_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   // compressed byte input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_new_image,
   // pixel output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [15:0]                        rsp_pixel,
   output logic                               rsp_row_end,
   output logic                               rsp_last,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcxrle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcxrle_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DEPTH = 2 * MAX_LINE_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(MAX_LINE_BYTES + 1);
   localparam int PW    = $clog2(3 * MAX_LINE_BYTES + 1);
   localparam int CW    = (LW > pcxrle_pkg::CSR_DATA_W) ? LW : pcxrle_pkg::CSR_DATA_W;

   // Configuration registers
   logic        mode_ff;
   logic [12:0] width_ff;
   logic [12:0] bpl_ff;
   logic [7:0]  rsh_ff;
   logic [7:0]  gsh_ff;
   logic [7:0]  bsh_ff;

   // Sequencer state
   logic          busy_ff, busy_in;
   logic [7:0]    run_byte_ff, run_byte_in;
   logic [5:0]    run_rem_ff, run_rem_in;
   logic          pending_ff, pending_in;
   logic [5:0]    pend_cnt_ff, pend_cnt_in;
   logic [PW-1:0] pos_ff, pos_in;

   // Stage behind the memory read, and the output register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_rgb_ff;
   logic        s1_rend_ff;
   logic        s1_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pixel_ff;
   logic        rsp_row_end_ff;
   logic        rsp_last_ff;

   // Line store
   logic [7:0]    line_mem [DEPTH];
   logic [7:0]    rd_red_ff;
   logic [7:0]    rd_green_ff;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_red_addr;
   logic [AW-1:0] rd_green_addr;

   // Derived configuration
   logic [LW-1:0] bpl_c;
   logic [LW-1:0] width_c;
   logic [LW-1:0] vis_c;
   logic [PW-1:0] len_p;
   logic [PW-1:0] two_bpl;
   logic          carry;

   // Placement
   logic          req_xfer;
   logic          out_move;
   logic          can_adv;
   logic          is_mark;
   logic          pend_eff;
   logic [PW-1:0] pos_base;
   logic          place_go;
   logic [7:0]    place_byte;
   logic [5:0]    place_rem;
   logic [PW-1:0] pos_src;
   logic [PW-1:0] pos_p;
   logic [PW-1:0] pos_next;
   logic [PW-1:0] x_p;
   logic          line_end;
   logic          place_done;
   logic          in_blue;
   logic          emit;
   logic          emit_rend;
   logic          emit_last;
   logic [15:0]   s1_pixel;

   // Register clamping: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (bpl_ff == '0) begin
         bpl_c = LW'(1);
      end else if (CW'(bpl_ff) > CW'(MAX_LINE_BYTES)) begin
         bpl_c = LW'(MAX_LINE_BYTES);
      end else begin
         bpl_c = LW'(bpl_ff);
      end
      if (width_ff == '0) begin
         width_c = LW'(1);
      end else if (CW'(width_ff) > CW'(MAX_LINE_BYTES)) begin
         width_c = LW'(MAX_LINE_BYTES);
      end else begin
         width_c = LW'(width_ff);
      end
      vis_c   = (width_c < bpl_c) ? width_c : bpl_c;
      two_bpl = PW'(bpl_c) << 1;
      len_p   = mode_ff ? (two_bpl + PW'(bpl_c)) : PW'(bpl_c);
      carry   = !mode_ff && (bpl_c == width_c);
   end

   // Handshakes
   assign out_move  = !rsp_valid_ff || rsp_ready;
   assign can_adv   = !s1_valid_ff || out_move;
   assign req_ready = !busy_ff && can_adv;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Pick the byte to place: the running fill byte or a freshly accepted one
   always_comb begin
      is_mark  = (req_data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
      pend_eff = pending_ff && !req_new_image;
      pos_base = req_new_image ? '0 : pos_ff;
      if (busy_ff) begin
         place_go   = can_adv;
         place_byte = run_byte_ff;
         place_rem  = run_rem_ff;
         pos_src    = pos_ff;
      end else begin
         place_go   = req_xfer && (pend_eff ? (pend_cnt_ff != '0) : !is_mark);
         place_byte = req_data_byte;
         place_rem  = pend_eff ? pend_cnt_ff : 6'd1;
         pos_src    = pos_base;
      end
   end

   // Position, plane and visibility of the byte being placed
   always_comb begin
      pos_p      = (pos_src >= len_p) ? '0 : pos_src;
      pos_next   = pos_p + PW'(1);
      line_end   = pos_next >= len_p;
      x_p        = pos_p - two_bpl;
      in_blue    = mode_ff && (pos_p >= two_bpl);
      if (!mode_ff) begin
         emit      = pos_p < PW'(vis_c);
         emit_rend = pos_p == PW'(vis_c) - PW'(1);
      end else begin
         emit      = in_blue && (x_p < PW'(vis_c));
         emit_rend = x_p == PW'(vis_c) - PW'(1);
      end
      // no further pixel from this byte once the run ends or the row's last pixel is out
      place_done = (place_rem == 6'd1) || (line_end && !carry);
      emit_last  = (place_rem == 6'd1) || (emit_rend && !carry);
      mem_we        = place_go && mode_ff && !in_blue;
      mem_re        = place_go && emit && mode_ff;
      wr_addr       = AW'(pos_p);
      rd_red_addr   = AW'(x_p);
      rd_green_addr = AW'(x_p + PW'(bpl_c));
   end

   // Sequencer next state
   always_comb begin
      busy_in     = busy_ff;
      run_byte_in = run_byte_ff;
      run_rem_in  = run_rem_ff;
      pending_in  = pending_ff;
      pend_cnt_in = pend_cnt_ff;
      pos_in      = pos_ff;
      if (req_xfer) begin
         pos_in = pos_base;
         if (pend_eff) begin
            pending_in  = 1'b0;
            pend_cnt_in = '0;
         end else if (is_mark) begin
            pending_in  = 1'b1;
            pend_cnt_in = req_data_byte[5:0] & pcxrle_pkg::RUN_MASK[5:0];
         end else begin
            pending_in  = 1'b0;
         end
      end
      if (place_go) begin
         pos_in      = line_end ? '0 : pos_next;
         busy_in     = !place_done;
         run_byte_in = place_byte;
         run_rem_in  = place_rem - 6'd1;
      end
   end

   // Pipeline valid bits
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (out_move) begin
         s1_valid_in = 1'b0;
      end
      if (place_go && emit) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;
   end

   assign s1_pixel = s1_rgb_ff ?
      (pcxrle_pkg::channel(rd_red_ff, rsh_ff) | pcxrle_pkg::channel(rd_green_ff, gsh_ff) |
       pcxrle_pkg::channel(s1_byte_ff, bsh_ff)) :
      {8'd0, s1_byte_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= pcxrle_pkg::RST_PLANES_MODE;
         width_ff     <= pcxrle_pkg::RST_IMAGE_WIDTH;
         bpl_ff       <= pcxrle_pkg::RST_BYTES_PER_LINE;
         rsh_ff       <= pcxrle_pkg::RST_RED_SHIFTS;
         gsh_ff       <= pcxrle_pkg::RST_GREEN_SHIFTS;
         bsh_ff       <= pcxrle_pkg::RST_BLUE_SHIFTS;
         busy_ff      <= 1'b0;
         run_rem_ff   <= '0;
         pending_ff   <= 1'b0;
         pend_cnt_ff  <= '0;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pcxrle_pkg::REG_PLANES_MODE:    mode_ff  <= csr_data[0];
               pcxrle_pkg::REG_IMAGE_WIDTH:    width_ff <= csr_data[12:0];
               pcxrle_pkg::REG_BYTES_PER_LINE: bpl_ff   <= csr_data[12:0];
               pcxrle_pkg::REG_RED_SHIFTS:     rsh_ff   <= csr_data[7:0];
               pcxrle_pkg::REG_GREEN_SHIFTS:   gsh_ff   <= csr_data[7:0];
               pcxrle_pkg::REG_BLUE_SHIFTS:    bsh_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         busy_ff      <= busy_in;
         run_rem_ff   <= run_rem_in;
         pending_ff   <= pending_in;
         pend_cnt_ff  <= pend_cnt_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      if (place_go && emit) begin
         s1_byte_ff <= place_byte;
         s1_rgb_ff  <= mode_ff;
         s1_rend_ff <= emit_rend;
         s1_last_ff <= emit_last;
      end
      if (out_move && s1_valid_ff) begin
         rsp_pixel_ff   <= s1_pixel;
         rsp_row_end_ff <= s1_rend_ff;
         rsp_last_ff    <= s1_last_ff;
      end
   end

   // Line store: red/green write, two registered reads for a visible blue byte
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[wr_addr] <= place_byte;
      end
      if (mem_re) begin
         rd_red_ff   <= line_mem[rd_red_addr];
         rd_green_ff <= line_mem[rd_green_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel   = rsp_pixel_ff;
   assign rsp_row_end = rsp_row_end_ff;
   assign rsp_last    = rsp_last_ff;

   // A running fill never coexists with a waiting run marker
   a_busy_no_pending: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pending_ff)
      else $error("run in progress while a marker is pending");

   // A held pixel behind the output register is neither lost nor altered
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_move) |=> (s1_valid_ff && $stable(s1_byte_ff) &&
                                      (!s1_rgb_ff ||
                                       ($stable(rd_red_ff) && $stable(rd_green_ff)))))
      else $error("stalled pixel stage changed");

   // The last placement of a byte releases the sequencer for new input
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      (place_go && place_done) |=> !busy_ff)
      else $error("sequencer stayed busy after final placement");

   // The line store is never written and read by the same placement
   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("line store written and read together");

endmodule
